// ===== rtl/door_access_lock_controller_defines.svh =====
// ----------------------------------------------------------------------------
// Door access lock controller assertion macros
// Shared assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DOOR_ACCESS_LOCK_CONTROLLER_DEFINES_SVH
`define DOOR_ACCESS_LOCK_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DALC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DALC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dalc_pkg.sv =====
// ----------------------------------------------------------------------------
// Door access lock controller package
// Opcodes, result codes, register indexes and timer helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dalc_pkg;

    localparam int TIMER_WIDTH      = 16;
    localparam int RELOCK_TICKS     = 5;
    localparam int MS_PER_SECOND    = 1000;
    localparam int TICK_MS          = 100;
    localparam int TICKS_PER_SECOND = MS_PER_SECOND / TICK_MS;
    localparam int RELOCK_WIDTH     = $clog2(RELOCK_TICKS + 1);
    localparam int CARD_WIDTH       = 32;
    localparam int CFG_DATA_WIDTH   = 8;
    localparam int CFG_ADDR_WIDTH   = 2;

    typedef logic [TIMER_WIDTH-1:0]    timer_t;
    typedef logic [RELOCK_WIDTH-1:0]   relock_cnt_t;
    typedef logic [CFG_DATA_WIDTH-1:0] seconds_t;

    typedef enum logic [2:0] {
        OP_TICK          = 3'd0,
        OP_CARD_SWIPE    = 3'd1,
        OP_BUMP          = 3'd2,
        OP_REMOTE_UNLOCK = 3'd3,
        OP_REMOTE_LOCK   = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ACC_NONE       = 2'd0,
        ACC_GRANTED    = 2'd1,
        ACC_DENIED     = 2'd2,
        ACC_LOCKED_OUT = 2'd3
    } access_t;

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_SENSOR_ENABLED = 2'd0,
        REG_FIXED_DELAY    = 2'd1,
        REG_SENSOR_TIMEOUT = 2'd2,
        REG_OPEN_ALARM     = 2'd3
    } cfg_index_t;

    localparam relock_cnt_t RELOCK_LOAD = RELOCK_WIDTH'(RELOCK_TICKS);

    // Saturating increment of an elapsed-tick counter.
    function automatic timer_t sat_inc(input timer_t value);
        return (value == '1) ? value : value + timer_t'(1);
    endfunction

    // True once the elapsed tick count covers the given number of seconds.
    function automatic logic reached(input timer_t elapsed, input seconds_t secs);
        timer_t limit;
        limit = timer_t'(secs) * timer_t'(TICKS_PER_SECOND);
        return elapsed >= limit;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/door_access_lock_controller.sv =====
// ----------------------------------------------------------------------------
// Door access lock controller
// An item is taken into an input register whenever that register is empty or
// moves on in the same cycle, so one item is accepted in every clock cycle
// while the result side keeps up. The lock state is updated by one pass of
// short logic between the input register and the result register, so each
// item's result is offered on the result channel once it has moved from the
// input register into the result register; the sustained rate is one item
// per cycle. Ticks (every 100 ms) drive the unlock and door-open timers,
// card swipes and bumps raise an unlock request that the next usable tick
// carries out, and remote lock and unlock commands only change the lock
// output and set command ok. Configuration is written through a plain write
// port and must only be changed while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "door_access_lock_controller_defines.svh"

module door_access_lock_controller (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    // Configuration write port.
    input  wire logic                               cfg_we,
    input  wire logic [dalc_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  wire logic [dalc_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,

    // Input item channel.
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [2:0]                         s_opcode,
    input  wire logic                               s_tag_known,
    input  wire logic                               s_lockout_active,
    input  wire logic                               s_door_open,
    input  wire logic [dalc_pkg::CARD_WIDTH-1:0]    s_card_id,

    // Result item channel.
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_lock_level,
    output logic                                    m_relay_level,
    output logic                                    m_buzzer_level,
    output logic [1:0]                              m_access_result,
    output logic                                    m_alert_pulse,
    output logic                                    m_command_ok,
    output logic [dalc_pkg::CARD_WIDTH-1:0]         m_card_echo
);

    import dalc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic     sensor_enabled_reg;
    seconds_t fixed_delay_reg;
    seconds_t sensor_timeout_reg;
    seconds_t open_alarm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sensor_enabled_reg <= 1'b0;
            fixed_delay_reg    <= seconds_t'(5);
            sensor_timeout_reg <= seconds_t'(10);
            open_alarm_reg     <= seconds_t'(0);
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_addr))
                REG_SENSOR_ENABLED: sensor_enabled_reg <= cfg_wdata[0];
                REG_FIXED_DELAY:    fixed_delay_reg    <= cfg_wdata;
                REG_SENSOR_TIMEOUT: sensor_timeout_reg <= cfg_wdata;
                REG_OPEN_ALARM:     open_alarm_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register. The item moves on whenever the result register is
    // free or is being emptied in this cycle.
    // ------------------------------------------------------------------
    logic                  in_valid_reg;
    logic [2:0]            in_opcode_reg;
    logic                  in_tag_known_reg;
    logic                  in_lockout_reg;
    logic                  in_door_open_reg;
    logic [CARD_WIDTH-1:0] in_card_id_reg;
    logic                  advance;

    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_opcode_reg    <= s_opcode;
            in_tag_known_reg <= s_tag_known;
            in_lockout_reg   <= s_lockout_active;
            in_door_open_reg <= s_door_open;
            in_card_id_reg   <= s_card_id;
        end
    end

    // ------------------------------------------------------------------
    // Controller state.
    // ------------------------------------------------------------------
    logic        unlock_request_reg, unlock_request_next;
    logic        unlock_timing_reg,  unlock_timing_next;
    timer_t      unlock_elapsed_reg, unlock_elapsed_next;
    logic        prev_open_reg,      prev_open_next;
    logic        open_timing_reg,    open_timing_next;
    timer_t      open_elapsed_reg,   open_elapsed_next;
    relock_cnt_t relock_cnt_reg,     relock_cnt_next;
    logic        lock_reg,           lock_next;
    logic        relay_reg,          relay_next;
    logic        buzzer_reg,         buzzer_next;

    access_t               access_next;
    logic                  alert_next;
    logic                  cmd_ok_next;
    logic [CARD_WIDTH-1:0] echo_next;

    // One pass of the controller for the item in the input register. The
    // variables are updated in the same order as the behavior is defined:
    // timers advance first, then the relock wait, the pending unlock, and
    // finally the relock and alarm decisions.
    always_comb begin
        logic skip_alarm;

        unlock_request_next = unlock_request_reg;
        unlock_timing_next  = unlock_timing_reg;
        unlock_elapsed_next = unlock_elapsed_reg;
        prev_open_next      = prev_open_reg;
        open_timing_next    = open_timing_reg;
        open_elapsed_next   = open_elapsed_reg;
        relock_cnt_next     = relock_cnt_reg;
        lock_next           = lock_reg;
        relay_next          = relay_reg;
        buzzer_next         = buzzer_reg;
        access_next         = ACC_NONE;
        alert_next          = 1'b0;
        cmd_ok_next         = 1'b0;
        echo_next           = '0;
        skip_alarm          = 1'b0;

        unique case (in_opcode_reg)
            OP_TICK: begin
                if (unlock_timing_reg) begin
                    unlock_elapsed_next = sat_inc(unlock_elapsed_reg);
                end
                if (open_timing_reg) begin
                    open_elapsed_next = sat_inc(open_elapsed_reg);
                end

                if (relock_cnt_reg != '0) begin
                    // Relock wait: the sensor level is ignored until the
                    // count runs out, then the door locks.
                    relock_cnt_next = relock_cnt_reg - relock_cnt_t'(1);
                    if (relock_cnt_next == '0) begin
                        lock_next          = 1'b1;
                        relay_next         = 1'b0;
                        unlock_timing_next = 1'b0;
                    end else begin
                        skip_alarm = 1'b1;
                    end
                end else begin
                    if (unlock_request_reg) begin
                        lock_next           = 1'b0;
                        relay_next          = 1'b1;
                        unlock_timing_next  = 1'b1;
                        unlock_elapsed_next = '0;
                        unlock_request_next = 1'b0;
                    end

                    if (!sensor_enabled_reg) begin
                        skip_alarm = 1'b1;
                        if (unlock_timing_next &&
                            reached(unlock_elapsed_next, fixed_delay_reg)) begin
                            lock_next          = 1'b1;
                            relay_next         = 1'b0;
                            unlock_timing_next = 1'b0;
                        end
                    end else begin
                        if (prev_open_reg != in_door_open_reg) begin
                            prev_open_next = in_door_open_reg;
                            if (in_door_open_reg) begin
                                open_timing_next  = 1'b1;
                                open_elapsed_next = '0;
                            end else begin
                                buzzer_next      = 1'b0;
                                open_timing_next = 1'b0;
                            end
                        end

                        if (unlock_timing_next) begin
                            if (reached(unlock_elapsed_next, sensor_timeout_reg)) begin
                                lock_next          = 1'b1;
                                relay_next         = 1'b0;
                                unlock_timing_next = 1'b0;
                            end else if (prev_open_next) begin
                                relock_cnt_next = RELOCK_LOAD;
                                skip_alarm      = 1'b1;
                            end
                        end
                    end
                end

                // The door-open alarm turns the buzzer on; only a door seen
                // closed turns it off again.
                if (!skip_alarm && open_alarm_reg != '0 && open_timing_next &&
                    reached(open_elapsed_next, open_alarm_reg)) begin
                    buzzer_next = 1'b1;
                end
            end
            OP_CARD_SWIPE: begin
                echo_next = in_card_id_reg;
                if (!in_tag_known_reg) begin
                    access_next = ACC_DENIED;
                    alert_next  = 1'b1;
                end else if (in_lockout_reg) begin
                    access_next = ACC_LOCKED_OUT;
                    alert_next  = 1'b1;
                end else begin
                    access_next         = ACC_GRANTED;
                    unlock_request_next = 1'b1;
                end
            end
            OP_BUMP: begin
                unlock_request_next = 1'b1;
                cmd_ok_next         = 1'b1;
            end
            OP_REMOTE_UNLOCK: begin
                lock_next   = 1'b0;
                cmd_ok_next = 1'b1;
            end
            OP_REMOTE_LOCK: begin
                lock_next   = 1'b1;
                cmd_ok_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unlock_request_reg <= 1'b0;
            unlock_timing_reg  <= 1'b0;
            unlock_elapsed_reg <= '0;
            prev_open_reg      <= 1'b0;
            open_timing_reg    <= 1'b0;
            open_elapsed_reg   <= '0;
            relock_cnt_reg     <= '0;
            lock_reg           <= 1'b1;
            relay_reg          <= 1'b0;
            buzzer_reg         <= 1'b0;
        end else if (advance) begin
            unlock_request_reg <= unlock_request_next;
            unlock_timing_reg  <= unlock_timing_next;
            unlock_elapsed_reg <= unlock_elapsed_next;
            prev_open_reg      <= prev_open_next;
            open_timing_reg    <= open_timing_next;
            open_elapsed_reg   <= open_elapsed_next;
            relock_cnt_reg     <= relock_cnt_next;
            lock_reg           <= lock_next;
            relay_reg          <= relay_next;
            buzzer_reg         <= buzzer_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic                  m_valid_reg;
    logic                  m_lock_reg;
    logic                  m_relay_reg;
    logic                  m_buzzer_reg;
    access_t               m_access_reg;
    logic                  m_alert_reg;
    logic                  m_cmd_ok_reg;
    logic [CARD_WIDTH-1:0] m_echo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_lock_reg   <= lock_next;
            m_relay_reg  <= relay_next;
            m_buzzer_reg <= buzzer_next;
            m_access_reg <= access_next;
            m_alert_reg  <= alert_next;
            m_cmd_ok_reg <= cmd_ok_next;
            m_echo_reg   <= echo_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_lock_level    = m_lock_reg;
    assign m_relay_level   = m_relay_reg;
    assign m_buzzer_level  = m_buzzer_reg;
    assign m_access_result = m_access_reg;
    assign m_alert_pulse   = m_alert_reg;
    assign m_command_ok    = m_cmd_ok_reg;
    assign m_card_echo     = m_echo_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The relay is energized exactly while the unlock timer runs.
    `DALC_ASSERT_SAME(a_relay_tracks_timer, aclk, aresetn, 1'b1,
        relay_reg == unlock_timing_reg, "relay level differs from unlock timer state")
    // A relock wait only exists while the unlock timer runs.
    `DALC_ASSERT_SAME(a_relock_needs_timer, aclk, aresetn, relock_cnt_reg != '0,
        unlock_timing_reg, "relock wait without running unlock timer")
    // A card number is only echoed together with a swipe verdict.
    `DALC_ASSERT_SAME(a_echo_has_verdict, aclk, aresetn, m_valid_reg && m_echo_reg != '0,
        m_access_reg != ACC_NONE, "card echo without access result")
    // The buzzer can only switch on when a tick is processed.
    `DALC_ASSERT_NEXT(a_buzzer_on_tick, aclk, aresetn,
        !buzzer_reg && !(advance && in_opcode_reg == OP_TICK), !buzzer_reg,
        "buzzer turned on outside a tick")

endmodule

`default_nettype wire
